// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks are sampled on the rising
// clock edge and are switched off while the synchronous reset is held low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be true.
`define TWL_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// Whenever the first condition holds, the second must hold in the same cycle.
`define TWL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/twl_pkg.sv =====
package twl_pkg;

    // Width of the limit registers and of the configuration data port.
    localparam int LIMIT_W = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST = 24'd1000;
    localparam logic [LIMIT_W-1:0] RX_ENTER_LIMIT_RST = 24'd30000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_ENTER_LIMIT = 1'd1;

    // Opcode field encodings.
    localparam logic [1:0] OPC_IDLE = 2'd0;
    localparam logic [1:0] OPC_SEND = 2'd1;
    localparam logic [1:0] OPC_RECV = 2'd2;

    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 16;

    // Line drive patterns: bit 0 is tip, bit 1 is ring.
    localparam logic [1:0] DRV_NONE = 2'b00;
    localparam logic [1:0] DRV_TIP = 2'b01;
    localparam logic [1:0] DRV_RING = 2'b10;
    localparam logic [1:0] LINES_HIGH = 2'b11;
    localparam logic [1:0] LINES_TIP_HIGH = 2'b01;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [1:0] {
        K_IDLE = 2'd0,
        K_SEND = 2'd1,
        K_RECV = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_WRITE_TIMEOUT = 2'd1,
        ST_READ_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_TX_HIGH = 6'b000010,
        PH_TX_ACK = 6'b000100,
        PH_TX_REL = 6'b001000,
        PH_RX_DROP = 6'b010000,
        PH_RX_REL = 6'b100000
    } t_phase;

    // One classified tick as it sits in the queue.
    typedef struct packed {
        t_kind kind;
        logic [7:0] tx_byte;
        logic ring_level;
        logic tip_level;
    } t_cmd;

    // One result item; packed so that tip_pull_low lands in bit 0.
    typedef struct packed {
        logic [7:0] rx_byte;
        t_status status;
        logic done_res;
        logic busy_res;
        logic ring_pull_low;
        logic tip_pull_low;
    } t_result;

endpackage

// ===== rtl/twl_front.sv =====
module twl_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [twl_pkg::IN_DATA_W-1:0] i_data,
    output twl_pkg::t_cmd o_cmd,
    output logic o_cmd_valid,
    input  logic i_cmd_pop
);

    twl_pkg::t_cmd r_mem [2];
    logic r_wr_ptr;
    logic r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    twl_pkg::t_cmd w_cmd;
    logic w_push;

    // Opcode three and idle both become plain sampling ticks.
    always_comb begin
        w_cmd.tx_byte = i_data[9:2];
        w_cmd.tip_level = i_data[10];
        w_cmd.ring_level = i_data[11];
        unique case (i_data[1:0])
            twl_pkg::OPC_SEND: w_cmd.kind = twl_pkg::K_SEND;
            twl_pkg::OPC_RECV: w_cmd.kind = twl_pkg::K_RECV;
            default: w_cmd.kind = twl_pkg::K_IDLE;
        endcase
    end

    assign o_ready = (r_count != 2'd2);
    assign w_push = i_valid && o_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_cmd_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_cmd_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/twl_back.sv =====
module twl_back #(
    parameter int TIMER_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  twl_pkg::t_cmd i_cmd,
    input  logic i_cmd_valid,
    output logic o_cmd_pop,
    input  logic [twl_pkg::LIMIT_W-1:0] i_wait_limit,
    input  logic [twl_pkg::LIMIT_W-1:0] i_rx_enter_limit,
    output twl_pkg::t_result o_res,
    output logic o_res_valid,
    input  logic i_res_ready
);

    localparam int CMP_W = (TIMER_BITS > twl_pkg::LIMIT_W) ? TIMER_BITS : twl_pkg::LIMIT_W;

    twl_pkg::t_phase r_phase, n_phase;
    logic [2:0] r_bit_idx, n_bit_idx;
    logic [7:0] r_shift, n_shift;
    logic [TIMER_BITS-1:0] r_wait, n_wait;
    logic r_cur_bit, n_cur_bit;
    logic [1:0] r_drive, n_drive;
    twl_pkg::t_result r_res;
    logic r_res_valid;

    logic [CMP_W-1:0] w_cnt;
    logic [CMP_W-1:0] w_wait_lim;
    logic [CMP_W-1:0] w_rx_lim;
    logic w_to_wait;
    logic w_to_rx;
    logic [1:0] w_lines;
    logic w_other_tx;
    logic w_other_rx;
    logic w_fire;
    logic w_done;
    twl_pkg::t_status w_status;
    logic [7:0] w_rx_byte;

    // A limit beyond the counter range behaves as the counter's top value,
    // which the all-ones test covers.
    assign w_cnt = CMP_W'(r_wait);
    assign w_wait_lim = CMP_W'(i_wait_limit);
    assign w_rx_lim = CMP_W'(i_rx_enter_limit);
    assign w_to_wait = (w_cnt >= w_wait_lim) || (&r_wait);
    assign w_to_rx = (w_cnt >= w_rx_lim) || (&r_wait);

    assign w_lines = {i_cmd.ring_level, i_cmd.tip_level};
    assign w_other_tx = r_cur_bit ? i_cmd.tip_level : i_cmd.ring_level;
    assign w_other_rx = r_cur_bit ? i_cmd.ring_level : i_cmd.tip_level;

    assign w_fire = i_cmd_valid && (!r_res_valid || i_res_ready);
    assign o_cmd_pop = w_fire;

    always_comb begin
        n_phase = r_phase;
        n_bit_idx = r_bit_idx;
        n_shift = r_shift;
        n_wait = r_wait;
        n_cur_bit = r_cur_bit;
        n_drive = r_drive;
        w_done = 1'b0;
        w_status = twl_pkg::ST_OK;
        w_rx_byte = 8'd0;

        unique case (r_phase)
            twl_pkg::PH_TX_HIGH: begin
                if (w_lines != twl_pkg::LINES_HIGH) begin
                    if (w_to_wait) begin
                        w_done = 1'b1;
                        w_status = twl_pkg::ST_WRITE_TIMEOUT;
                    end else begin
                        n_wait = r_wait + TIMER_BITS'(1);
                    end
                end else begin
                    n_cur_bit = r_shift[0];
                    n_drive = r_shift[0] ? twl_pkg::DRV_RING : twl_pkg::DRV_TIP;
                    n_wait = '0;
                    n_phase = twl_pkg::PH_TX_ACK;
                end
            end
            twl_pkg::PH_TX_ACK: begin
                if (w_other_tx) begin
                    if (w_to_wait) begin
                        w_done = 1'b1;
                        w_status = twl_pkg::ST_WRITE_TIMEOUT;
                    end else begin
                        n_wait = r_wait + TIMER_BITS'(1);
                    end
                end else begin
                    n_drive = twl_pkg::DRV_NONE;
                    n_wait = '0;
                    n_phase = twl_pkg::PH_TX_REL;
                end
            end
            twl_pkg::PH_TX_REL: begin
                if (!w_other_tx) begin
                    if (w_to_wait) begin
                        w_done = 1'b1;
                        w_status = twl_pkg::ST_WRITE_TIMEOUT;
                    end else begin
                        n_wait = r_wait + TIMER_BITS'(1);
                    end
                end else begin
                    n_shift = {1'b0, r_shift[7:1]};
                    n_wait = '0;
                    if (r_bit_idx == twl_pkg::LAST_BIT) begin
                        w_done = 1'b1;
                    end else begin
                        n_bit_idx = r_bit_idx + 3'd1;
                        n_phase = twl_pkg::PH_TX_HIGH;
                    end
                end
            end
            twl_pkg::PH_RX_DROP: begin
                if (w_lines == twl_pkg::LINES_HIGH) begin
                    if (w_to_rx) begin
                        w_done = 1'b1;
                        w_status = twl_pkg::ST_READ_TIMEOUT;
                    end else begin
                        n_wait = r_wait + TIMER_BITS'(1);
                    end
                end else begin
                    // Ring low with tip high marks a one; anything else is a zero.
                    n_cur_bit = (w_lines == twl_pkg::LINES_TIP_HIGH);
                    n_shift = {n_cur_bit, r_shift[7:1]};
                    n_drive = n_cur_bit ? twl_pkg::DRV_TIP : twl_pkg::DRV_RING;
                    n_wait = '0;
                    n_phase = twl_pkg::PH_RX_REL;
                end
            end
            twl_pkg::PH_RX_REL: begin
                if (!w_other_rx) begin
                    if (w_to_wait) begin
                        w_done = 1'b1;
                        w_status = twl_pkg::ST_READ_TIMEOUT;
                    end else begin
                        n_wait = r_wait + TIMER_BITS'(1);
                    end
                end else begin
                    n_drive = twl_pkg::DRV_NONE;
                    n_wait = '0;
                    if (r_bit_idx == twl_pkg::LAST_BIT) begin
                        w_done = 1'b1;
                        w_rx_byte = r_shift;
                    end else begin
                        n_bit_idx = r_bit_idx + 3'd1;
                        n_phase = twl_pkg::PH_RX_DROP;
                    end
                end
            end
            default: begin
                n_phase = twl_pkg::PH_IDLE;
                n_drive = twl_pkg::DRV_NONE;
                if (i_cmd.kind == twl_pkg::K_SEND || i_cmd.kind == twl_pkg::K_RECV) begin
                    n_bit_idx = 3'd0;
                    n_wait = '0;
                    n_cur_bit = 1'b0;
                    n_shift = (i_cmd.kind == twl_pkg::K_SEND) ? i_cmd.tx_byte : 8'd0;
                    n_phase = (i_cmd.kind == twl_pkg::K_SEND) ? twl_pkg::PH_TX_HIGH
                                                              : twl_pkg::PH_RX_DROP;
                end
            end
        endcase

        if (w_done) begin
            n_phase = twl_pkg::PH_IDLE;
            n_drive = twl_pkg::DRV_NONE;
            n_wait = '0;
            n_bit_idx = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= twl_pkg::PH_IDLE;
            r_bit_idx <= 3'd0;
            r_shift <= 8'd0;
            r_wait <= '0;
            r_cur_bit <= 1'b0;
            r_drive <= twl_pkg::DRV_NONE;
            r_res_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase <= n_phase;
                r_bit_idx <= n_bit_idx;
                r_shift <= n_shift;
                r_wait <= n_wait;
                r_cur_bit <= n_cur_bit;
                r_drive <= n_drive;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res.tip_pull_low <= n_drive[0];
            r_res.ring_pull_low <= n_drive[1];
            r_res.busy_res <= (n_phase != twl_pkg::PH_IDLE);
            r_res.done_res <= w_done;
            r_res.status <= w_status;
            r_res.rx_byte <= w_rx_byte;
        end
    end

    assign o_res = r_res;
    assign o_res_valid = r_res_valid;

endmodule

// ===== rtl/two_wire_handshake_byte_link_unit.sv =====
// Two-wire open-drain byte link (tip and ring lines) with a handshake per bit.
// Every input item on the s_axis channel is one sampling tick: an opcode
// (idle, start send, start receive), the byte to send and the sampled levels
// of both lines. Every input item yields exactly one result item on the
// m_axis channel: the pull-low controls for both lines, busy, done, the
// completion status and the received byte.
// Items enter a two-entry queue and are then stepped through the bit
// handshake state machine, whose result is held in an output register.
// An accepted item passes through the queue and then the output register
// before its result turns valid; one item is taken per cycle as long as
// results are consumed. The throughput is set by the single handshake
// state machine, which steps once per item.
// The cfg port writes the two timeout limits; writes take effect at once.
// Reset (synchronous, active low) empties the queue and output register,
// returns the state machine to idle with both lines released and restores
// the default limits. If the receiver stalls, the result stays in place, the
// queue fills, and s_axis tready drops once both queue entries are taken.
`include "assert_macros.svh"

module two_wire_handshake_byte_link_unit #(
    parameter int TIMER_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // [1:0] opcode, [9:2] tx_byte, [10] tip_level, [11] ring_level, [15:12] zero
    input  logic [twl_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // [0] tip_pull_low, [1] ring_pull_low, [2] busy_res, [3] done_res,
    // [5:4] status, [13:6] rx_byte, [15:14] zero
    output logic [twl_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic i_cfg_we,
    input  logic [twl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [twl_pkg::LIMIT_W-1:0] i_cfg_data
);

    logic [twl_pkg::LIMIT_W-1:0] r_wait_limit;
    logic [twl_pkg::LIMIT_W-1:0] r_rx_enter_limit;

    twl_pkg::t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_pop;
    twl_pkg::t_result w_res;

    // Limit registers; an index outside the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_limit <= twl_pkg::WAIT_LIMIT_RST;
            r_rx_enter_limit <= twl_pkg::RX_ENTER_LIMIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == twl_pkg::CFG_WAIT_LIMIT) begin
                r_wait_limit <= i_cfg_data;
            end else if (i_cfg_idx == twl_pkg::CFG_RX_ENTER_LIMIT) begin
                r_rx_enter_limit <= i_cfg_data;
            end
        end
    end

    // The front end accepts and classifies ticks into the queue.
    twl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    // The back end runs the bit handshake and registers each result.
    twl_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cmd_valid      (w_cmd_valid),
        .o_cmd_pop        (w_cmd_pop),
        .i_wait_limit     (r_wait_limit),
        .i_rx_enter_limit (r_rx_enter_limit),
        .o_res            (w_res),
        .o_res_valid      (o_m_axis_tvalid),
        .i_res_ready      (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {2'b00, w_res};

    // A finished transfer never reports itself as still busy.
    `TWL_ASSERT_IMPLY(a_done_not_busy, o_m_axis_tvalid && w_res.done_res, !w_res.busy_res,
        "done reported while busy")
    // A status other than ok only comes with done.
    `TWL_ASSERT_IMPLY(a_status_with_done, o_m_axis_tvalid && w_res.status != twl_pkg::ST_OK,
        w_res.done_res, "error status without done")
    // Lines are only driven while a transfer is in progress.
    `TWL_ASSERT_IMPLY(a_idle_released, o_m_axis_tvalid && !w_res.busy_res,
        !w_res.tip_pull_low && !w_res.ring_pull_low, "line driven while idle")
    // Both lines are never pulled low at the same time.
    `TWL_ASSERT_NEVER(a_one_line, o_m_axis_tvalid && w_res.tip_pull_low && w_res.ring_pull_low,
        "both lines driven")

endmodule

// ===== dv/tb_two_wire_handshake_byte_link_unit.sv =====
// Stream-level bench for the two-wire tip/ring byte link. The bench plays the
// peer on the far end of the lines: every input item carries one sampling
// tick (opcode, byte to send and the two sampled line levels), and every
// input item produces exactly one result item. A line-level model of the
// link runs alongside the block, steps once per accepted input item, and
// queues the result it expects. A monitor compares each accepted result with
// the oldest queued one, field by field.
module tb_two_wire_handshake_byte_link_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import twl_pkg::*;

    // The spare opcode encoding must behave like an idle tick.
    localparam logic [1:0] OPC_SPARE = 2'd3;
    // Cycles without any accepted item before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Cycles allowed after the last result for anything stray to show up.
    localparam int DRAIN_CYCLES = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // [1:0] opcode, [9:2] tx_byte, [10] tip_level, [11] ring_level, [15:12] zero
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [0] tip_pull_low, [1] ring_pull_low, [2] busy_res, [3] done_res,
    // [5:4] status, [13:6] rx_byte, [15:14] zero
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [LIMIT_W-1:0]    i_cfg_data = '0;

    two_wire_handshake_byte_link_unit #(
        .TIMER_BITS(24)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Line-level model of the link. These variables mirror the block's
    // state after the most recently accepted input item.
    // ------------------------------------------------------------------
    t_phase             lk_phase;
    logic [2:0]         lk_bit_idx;
    logic [7:0]         lk_shift;
    logic [LIMIT_W-1:0] lk_wait_cnt;
    logic               lk_cur_bit;
    logic [1:0]         lk_drive;
    logic [LIMIT_W-1:0] lim_wait;
    logic [LIMIT_W-1:0] lim_rx_enter;

    // Results the block still owes, oldest first.
    t_result pending_line_results[$];

    int  mismatches = 0;
    // When set, neither side inserts idle cycles.
    bit  steady = 1'b0;

    // Counts one waiting tick; returns 1 once the wait has run past its
    // limit. The counter is as wide as the limit registers, so a limit
    // never needs clamping to the counter range.
    function automatic bit wait_expired(input logic [LIMIT_W-1:0] lim);
        if (lk_wait_cnt >= lim) begin
            return 1'b1;
        end
        lk_wait_cnt = lk_wait_cnt + 1'b1;
        return 1'b0;
    endfunction

    // Advances the link model by one sampling tick and returns the result
    // item that the tick should produce.
    function automatic t_result predict_link_tick(input logic [1:0] op,
                                                  input logic [7:0] txb,
                                                  input logic tip,
                                                  input logic ring);
        t_result    res;
        logic [1:0] lines;
        logic       other;
        logic       done;
        t_status    st;
        logic [7:0] rxb;
        lines = {ring, tip};
        done  = 1'b0;
        st    = ST_OK;
        rxb   = '0;
        case (lk_phase)
            PH_TX_HIGH: begin
                // Both lines must be idle high before the next bit goes out.
                if (lines != LINES_HIGH) begin
                    if (wait_expired(lim_wait)) begin
                        done = 1'b1;
                        st   = ST_WRITE_TIMEOUT;
                    end
                end else begin
                    lk_cur_bit  = lk_shift[0];
                    lk_drive    = lk_cur_bit ? DRV_RING : DRV_TIP;
                    lk_wait_cnt = '0;
                    lk_phase    = PH_TX_ACK;
                end
            end
            PH_TX_ACK: begin
                // The peer acknowledges on the line we are not pulling.
                other = lk_cur_bit ? tip : ring;
                if (other) begin
                    if (wait_expired(lim_wait)) begin
                        done = 1'b1;
                        st   = ST_WRITE_TIMEOUT;
                    end
                end else begin
                    lk_drive    = DRV_NONE;
                    lk_wait_cnt = '0;
                    lk_phase    = PH_TX_REL;
                end
            end
            PH_TX_REL: begin
                other = lk_cur_bit ? tip : ring;
                if (!other) begin
                    if (wait_expired(lim_wait)) begin
                        done = 1'b1;
                        st   = ST_WRITE_TIMEOUT;
                    end
                end else begin
                    lk_shift    = lk_shift >> 1;
                    lk_wait_cnt = '0;
                    if (lk_bit_idx == LAST_BIT) begin
                        done = 1'b1;
                        st   = ST_OK;
                    end else begin
                        lk_bit_idx = lk_bit_idx + 1'b1;
                        lk_phase   = PH_TX_HIGH;
                    end
                end
            end
            PH_RX_DROP: begin
                // Ring low alone means a one; tip low or both low mean a zero.
                if (lines == LINES_HIGH) begin
                    if (wait_expired(lim_rx_enter)) begin
                        done = 1'b1;
                        st   = ST_READ_TIMEOUT;
                    end
                end else begin
                    lk_cur_bit  = (lines == LINES_TIP_HIGH);
                    lk_shift    = {lk_cur_bit, lk_shift[7:1]};
                    lk_drive    = lk_cur_bit ? DRV_TIP : DRV_RING;
                    lk_wait_cnt = '0;
                    lk_phase    = PH_RX_REL;
                end
            end
            PH_RX_REL: begin
                other = lk_cur_bit ? ring : tip;
                if (!other) begin
                    if (wait_expired(lim_wait)) begin
                        done = 1'b1;
                        st   = ST_READ_TIMEOUT;
                    end
                end else begin
                    lk_drive    = DRV_NONE;
                    lk_wait_cnt = '0;
                    if (lk_bit_idx == LAST_BIT) begin
                        done = 1'b1;
                        st   = ST_OK;
                        rxb  = lk_shift;
                    end else begin
                        lk_bit_idx = lk_bit_idx + 1'b1;
                        lk_phase   = PH_RX_DROP;
                    end
                end
            end
            default: begin
                // Idle: only a send or receive opcode starts a transfer, and
                // the line levels of the start tick are not looked at.
                lk_phase = PH_IDLE;
                lk_drive = DRV_NONE;
                if (op == OPC_SEND || op == OPC_RECV) begin
                    lk_bit_idx  = '0;
                    lk_wait_cnt = '0;
                    lk_cur_bit  = 1'b0;
                    lk_shift    = (op == OPC_SEND) ? txb : 8'h00;
                    lk_phase    = (op == OPC_SEND) ? PH_TX_HIGH : PH_RX_DROP;
                end
            end
        endcase

        // Any ending, good or timed out, releases the lines and goes idle.
        if (done) begin
            lk_phase    = PH_IDLE;
            lk_drive    = DRV_NONE;
            lk_wait_cnt = '0;
            lk_bit_idx  = '0;
        end

        res.tip_pull_low  = lk_drive[0];
        res.ring_pull_low = lk_drive[1];
        res.busy_res      = (lk_phase != PH_IDLE);
        res.done_res      = done;
        res.status        = done ? st : ST_OK;
        res.rx_byte       = rxb;
        return res;
    endfunction

    // Line levels {ring, tip} that the far end would present on the next
    // tick. A cooperative peer moves the handshake on; otherwise it holds
    // the lines as they were, which keeps the block waiting. Now and then
    // the levels are plain noise.
    function automatic logic [1:0] peer_lines(input int coop);
        logic cooperate;
        if ($urandom_range(11) == 0) begin
            return 2'($urandom_range(3));
        end
        cooperate = ($urandom_range(99) < coop);
        case (lk_phase)
            PH_TX_HIGH: begin
                if (cooperate) begin
                    return LINES_HIGH;
                end
                return 2'($urandom_range(2));
            end
            PH_TX_ACK: begin
                // Acknowledge pulls the second line too; waiting leaves only
                // the block's own pull visible.
                if (cooperate) begin
                    return 2'b00;
                end
                return lk_cur_bit ? LINES_TIP_HIGH : 2'b10;
            end
            PH_TX_REL: begin
                if (cooperate) begin
                    return LINES_HIGH;
                end
                return lk_cur_bit ? 2'b10 : LINES_TIP_HIGH;
            end
            PH_RX_DROP: begin
                if (cooperate) begin
                    // Mostly a clean one or zero, sometimes both lines low.
                    if ($urandom_range(9) == 0) begin
                        return 2'b00;
                    end
                    return $urandom_range(1) ? LINES_TIP_HIGH : 2'b10;
                end
                return LINES_HIGH;
            end
            PH_RX_REL: begin
                if (cooperate) begin
                    return lk_cur_bit ? 2'b10 : LINES_TIP_HIGH;
                end
                return 2'b00;
            end
            default: begin
                return LINES_HIGH;
            end
        endcase
    endfunction

    task automatic reset_link_model();
        lk_phase     = PH_IDLE;
        lk_bit_idx   = '0;
        lk_shift     = '0;
        lk_wait_cnt  = '0;
        lk_cur_bit   = 1'b0;
        lk_drive     = DRV_NONE;
        lim_wait     = WAIT_LIMIT_RST;
        lim_rx_enter = RX_ENTER_LIMIT_RST;
    endtask

    // ------------------------------------------------------------------
    // Sender side. One call moves one input item; the expected result is
    // worked out at the edge where the item is accepted.
    // ------------------------------------------------------------------
    task automatic send_tick(input logic [1:0] op, input logic [7:0] txb,
                             input logic [1:0] lines);
        while (!steady && $urandom_range(99) < 8) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, lines[1], lines[0], txb, op};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        pending_line_results.push_back(predict_link_tick(op, txb, lines[0], lines[1]));
    endtask

    // Stops sending and waits until every owed result has been taken.
    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_line_results.size() != 0);
    endtask

    // Writes both timeout limits; only called once every owed result has been taken.
    task automatic set_limits(input logic [LIMIT_W-1:0] wait_ticks,
                              input logic [LIMIT_W-1:0] enter_ticks);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WAIT_LIMIT;
        i_cfg_data <= wait_ticks;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RX_ENTER_LIMIT;
        i_cfg_data <= enter_ticks;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        lim_wait     = wait_ticks;
        lim_rx_enter = enter_ticks;
    endtask

    // Random traffic against a peer that cooperates coop percent of the
    // time. In idle most items start a transfer; while busy the opcode is
    // random and must be ignored. If pause_at is hit, the sender holds off
    // until every owed result has come back.
    task automatic run_traffic(input int n_items, input int coop, input int pause_at);
        logic [1:0] op;
        int         pick;
        for (int i = 0; i < n_items; i++) begin
            if (i == pause_at) begin
                wait_for_results();
            end
            if (lk_phase == PH_IDLE) begin
                pick = $urandom_range(99);
                if (pick < 42) begin
                    op = OPC_SEND;
                end else if (pick < 84) begin
                    op = OPC_RECV;
                end else if (pick < 95) begin
                    op = OPC_IDLE;
                end else begin
                    op = OPC_SPARE;
                end
            end else begin
                op = 2'($urandom_range(3));
            end
            send_tick(op, 8'($urandom), peer_lines(coop));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Zero limits make every wait time out on its first waiting tick, which
    // lets each wait of both directions be hit in a few items. Also covers
    // idle and spare opcodes, a start opcode arriving while busy, a start
    // tick whose line levels must not matter, and both lines low at the
    // start of a received bit.
    task automatic test_opcodes_and_zero_limits();
        set_limits(24'd0, 24'd0);
        send_tick(OPC_IDLE, 8'h00, 2'b00);
        send_tick(OPC_SPARE, 8'hFF, LINES_HIGH);
        // Send of all ones: start tick with both lines low, then a receive
        // opcode while busy, then no acknowledge.
        send_tick(OPC_SEND, 8'hFF, 2'b00);
        send_tick(OPC_RECV, 8'h00, LINES_HIGH);
        send_tick(OPC_SEND, 8'h00, LINES_TIP_HIGH);
        // Send of all zeros that never sees the lines go high.
        send_tick(OPC_SEND, 8'h00, LINES_HIGH);
        send_tick(OPC_IDLE, 8'h00, 2'b10);
        // Send whose acknowledge is never released.
        send_tick(OPC_SEND, 8'h01, LINES_HIGH);
        send_tick(OPC_IDLE, 8'h00, LINES_HIGH);
        send_tick(OPC_IDLE, 8'h00, 2'b00);
        send_tick(OPC_IDLE, 8'h00, 2'b00);
        // Receive where both lines are low: a zero bit, then no release.
        send_tick(OPC_RECV, 8'hFF, LINES_HIGH);
        send_tick(OPC_IDLE, 8'h00, 2'b00);
        send_tick(OPC_IDLE, 8'h00, 2'b00);
        // Receive that never sees a line drop.
        send_tick(OPC_RECV, 8'h00, 2'b00);
        send_tick(OPC_IDLE, 8'h00, LINES_HIGH);
        wait_for_results();
    endtask

    // A limit of one allows one waiting tick and times out on the second.
    task automatic test_limit_of_one();
        set_limits(24'd1, 24'd1);
        send_tick(OPC_RECV, 8'h00, LINES_HIGH);
        send_tick(OPC_IDLE, 8'h00, LINES_HIGH);
        send_tick(OPC_IDLE, 8'h00, LINES_HIGH);
        wait_for_results();
    endtask

    // Tight limits with a hesitant peer: timeouts in every wait are common.
    // The middle round includes a full hold-off until the block has drained.
    task automatic test_short_limits();
        for (int r = 0; r < 3; r++) begin
            set_limits(24'($urandom_range(4, 1)), 24'($urandom_range(4, 1)));
            run_traffic(100, 60, (r == 1) ? 50 : -1);
            wait_for_results();
        end
    endtask

    // Moderate limits and a mostly willing peer: whole bytes go through in
    // both directions, with the odd timeout.
    task automatic test_moderate_limits();
        for (int r = 0; r < 3; r++) begin
            set_limits(24'($urandom_range(40, 5)), 24'($urandom_range(40, 5)));
            run_traffic(120, 85, -1);
            wait_for_results();
        end
    endtask

    // Full rate on both sides: one item in and one result out every cycle.
    task automatic test_back_to_back();
        set_limits(24'd8, 24'd20);
        steady = 1'b1;
        run_traffic(200, 85, -1);
        wait_for_results();
        steady = 1'b0;
    endtask

    // Largest limits, then the reset defaults again. No wait can run out
    // here, so every transfer ends with a clean status.
    task automatic test_wide_limits();
        set_limits(24'hFFFFFF, 24'hFFFFFF);
        run_traffic(150, 85, -1);
        wait_for_results();
        set_limits(WAIT_LIMIT_RST, RX_ENTER_LIMIT_RST);
        run_traffic(150, 85, -1);
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random back-pressure unless the steady window is on.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(99) >= 8);
    end

    // Result checker: every accepted result item is matched against the
    // oldest owed one.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[$bits(t_result)-1:0]);
            if (pending_line_results.size() == 0) begin
                $error("result item 0x%h arrived with nothing owed", o_m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_line_results.pop_front();
                if (got.tip_pull_low !== want.tip_pull_low) begin
                    $error("tip_pull_low: expected %0d, got %0d",
                           want.tip_pull_low, got.tip_pull_low);
                    mismatches++;
                end
                if (got.ring_pull_low !== want.ring_pull_low) begin
                    $error("ring_pull_low: expected %0d, got %0d",
                           want.ring_pull_low, got.ring_pull_low);
                    mismatches++;
                end
                if (got.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                    mismatches++;
                end
                if (got.done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                    mismatches++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.rx_byte !== want.rx_byte) begin
                    $error("rx_byte: expected 0x%h, got 0x%h", want.rx_byte, got.rx_byte);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no item moving on either side
    // means the block is hung.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence: one reset, the directed tests, then the random ones.
    initial begin
        reset_link_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_opcodes_and_zero_limits();
        test_limit_of_one();
        test_short_limits();
        test_moderate_limits();
        test_back_to_back();
        test_wide_limits();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_line_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/twl_pkg.sv
rtl/twl_front.sv
rtl/twl_back.sv
rtl/two_wire_handshake_byte_link_unit.sv
dv/tb_two_wire_handshake_byte_link_unit.sv
